/* src/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

/* src/fws_pkg.sv */
`default_nettype none
package fws_pkg;
  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT, ST_LOW_SETUP, ST_LOW_MUL, ST_LOW_MUL2, ST_LOW_DIV, ST_LOW_T2,
    ST_LOW_T2DIV, ST_UP_INIT, ST_UP_MUL, ST_UP_MUL2, ST_UP_DIV, ST_EMIT
  } fws_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic sort_step;
    logic low_init;
    logic low_mul;
    logic mul_hi;
    logic div_start;
    logic low_t1_take;
    logic low_t2_mul;
    logic low_t2_take;
    logic low_next;
    logic up_init;
    logic up_mul;
    logic up_take;
    logic emit_init;
    logic emit;
  } fws_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic few;
    logic low_done;
    logic up_done;
    logic div_done;
    logic emit_last;
    logic t2_zero;
  } fws_sts_t;
endpackage
`default_nettype wire

/* src/fws_div.sv */
`default_nettype none
module fws_div
  import fws_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [95:0]  dividend,
  input  wire logic [47:0]  divisor,
  output logic              done,
  output logic [31:0]       quotient
);
  logic [95:0] num_r, num_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r;
  logic [32:0] q_r, q_nxt;
  logic        sat_r, sat_nxt, run_r, zero_r;
  logic [6:0]  cnt_r;
  logic [48:0] sh, df;
  logic        qb;

  always_comb begin
    sh = {rem_r[47:0], num_r[95]};
    df = sh - {1'b0, den_r};
    qb = (rem_r[48] | sh[48]) | !df[48];
    rem_nxt = qb ? df : sh;
    num_nxt = {num_r[94:0], 1'b0};
    q_nxt = q_r;
    sat_nxt = sat_r;
    if (!sat_r) begin
      q_nxt = {q_r[31:0], qb};
      if (q_r[31]) sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd0;
        num_r <= dividend;
        rem_r <= '0;
        den_r <= divisor;
        q_r <= '0;
        sat_r <= 1'b0;
        zero_r <= (divisor == '0);
      end else if (run_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        q_r <= q_nxt;
        sat_r <= sat_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd95) begin
          run_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (zero_r | sat_r) ? SAT32 : q_r[31:0];
endmodule
`default_nettype wire

/* src/fws_ctrl.sv */
`default_nettype none
module fws_ctrl
  import fws_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_last_content,
  input  wire fws_sts_t sts,
  output logic          busy,
  output fws_cmd_t      cmd
);
  fws_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (start && in_last_content) state_nxt = ST_SORT;
      ST_SORT:      if (sts.sort_done) state_nxt = sts.few ? ST_EMIT : ST_LOW_SETUP;
      ST_LOW_SETUP: state_nxt = sts.low_done ? ST_UP_INIT : ST_LOW_MUL;
      ST_LOW_MUL:   state_nxt = ST_LOW_MUL2;
      ST_LOW_MUL2:  state_nxt = ST_LOW_DIV;
      ST_LOW_DIV:   if (sts.div_done) state_nxt = ST_LOW_T2;
      ST_LOW_T2:    state_nxt = sts.t2_zero ? ST_LOW_SETUP : ST_LOW_T2DIV;
      ST_LOW_T2DIV: if (sts.div_done) state_nxt = ST_LOW_SETUP;
      ST_UP_INIT:   state_nxt = sts.up_done ? ST_EMIT : ST_UP_MUL;
      ST_UP_MUL:    state_nxt = ST_UP_MUL2;
      ST_UP_MUL2:   state_nxt = ST_UP_DIV;
      ST_UP_DIV:    if (sts.div_done) state_nxt = ST_UP_INIT;
      ST_EMIT:      if (sts.emit_last) state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_LOAD);
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = start;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.low_init = sts.sort_done;
        cmd.emit_init = sts.sort_done;
      end
      ST_LOW_SETUP: begin
        cmd.up_init = sts.low_done;
      end
      ST_LOW_MUL: begin
        cmd.low_mul = 1'b1;
      end
      ST_LOW_MUL2: begin
        cmd.low_mul = 1'b1;
        cmd.mul_hi = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_LOW_DIV: cmd.low_t1_take = sts.div_done;
      ST_LOW_T2: begin
        cmd.low_t2_mul = 1'b1;
        cmd.div_start = !sts.t2_zero;
        cmd.low_next = sts.t2_zero;
      end
      ST_LOW_T2DIV: begin
        cmd.low_t2_take = sts.div_done;
        cmd.low_next = sts.div_done;
      end
      ST_UP_INIT: cmd.emit_init = sts.up_done;
      ST_UP_MUL: begin
        cmd.up_mul = 1'b1;
      end
      ST_UP_MUL2: begin
        cmd.up_mul = 1'b1;
        cmd.mul_hi = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_UP_DIV: cmd.up_take = sts.div_done;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clear = sts.emit_last;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

/* src/fws_dp.sv */
`default_nettype none
`include "assert_macros.svh"
module fws_dp
  import fws_pkg::*;
#(
  parameter int MAX_CONTENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire fws_cmd_t    cmd,
  input  wire logic [23:0] in_satisfied_count,
  input  wire logic [23:0] in_unsatisfied_count,
  input  wire logic [16:0] in_face_reliability,
  input  wire logic [16:0] in_reliability_threshold,
  input  wire logic [1:0]  in_priority_class,
  output fws_sts_t         sts,
  output logic             out_strobe,
  output logic [5:0]       out_content_position,
  output logic [31:0]      out_weight,
  output logic             out_last_result
);
  localparam int IW = $clog2(MAX_CONTENTS);
  localparam int CW = $clog2(MAX_CONTENTS + 1);

  logic [23:0] s_mem [MAX_CONTENTS];
  logic [23:0] u_mem [MAX_CONTENTS];
  logic [16:0] r_mem [MAX_CONTENTS];
  logic [1:0]  c_mem [MAX_CONTENTS];
  logic        rel_mem [MAX_CONTENTS];
  logic [31:0] lo_mem [MAX_CONTENTS];
  logic [31:0] up_mem [MAX_CONTENTS];
  logic [IW-1:0] ord_mem [MAX_CONTENTS];

  logic [CW-1:0] cnt_r, n_r, scan_r, k_r, e_r;
  logic [1:0]    cls_r;
  logic          sdone_r;
  logic [IW-1:0] a_r, b_r;
  logic [31:0]   t1_r, lo_new;
  logic [95:0]   dvd_r;
  logic [47:0]   dvs_r;
  logic          dstart_r;
  logic          ddone;
  logic [31:0]   dq;
  logic [47:0]   p_num, p_den;
  logic [16:0]   onem;
  logic [40:0]   t2n;
  logic [47:0]   mx;
  logic [31:0]   my;
  logic [23:0]   mh;
  logic [55:0]   mp;
  logic [31:0]   wsel, ubi;
  logic [32:0]   usum, msum;
  logic [IW-1:0] ei;
  logic [CW-1:0] npos;

  fws_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(dvd_r), .divisor(dvs_r),
    .done(ddone), .quotient(dq)
  );

  assign onem = 17'd65536 - r_mem[b_r];
  assign t2n = s_mem[b_r] * onem;
  assign ei = e_r[IW-1:0];
  assign npos = n_r - CW'(1);
  assign lo_new = (cmd.low_t2_take && dq > t1_r) ? dq : t1_r;

  // 48 x 32 product in two halves, low half first, then the high half with mul_hi
  always_comb begin
    mx = cmd.up_mul ? p_den : p_num;
    my = cmd.up_mul ? up_mem[b_r] : lo_mem[a_r];
    mh = cmd.mul_hi ? mx[47:24] : mx[23:0];
    mp = mh * my;
  end

  always_comb begin
    sts = '0;
    sts.sort_done = sdone_r;
    sts.few = (n_r < CW'(2));
    sts.low_done = (k_r + CW'(1) >= n_r);
    sts.up_done = (k_r <= CW'(1));
    sts.div_done = ddone;
    sts.emit_last = (e_r + CW'(1) >= cnt_r);
    sts.t2_zero = r_mem[b_r][16];
  end

  always_ff @(posedge clk) begin
    p_num <= s_mem[b_r] * u_mem[a_r];
    p_den <= s_mem[a_r] * u_mem[b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_strobe <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      dstart_r <= 1'b0;
      if (cmd.load && cnt_r < CW'(MAX_CONTENTS)) begin
        s_mem[cnt_r[IW-1:0]] <= in_satisfied_count;
        u_mem[cnt_r[IW-1:0]] <= in_unsatisfied_count;
        r_mem[cnt_r[IW-1:0]] <= in_reliability_threshold;
        c_mem[cnt_r[IW-1:0]] <= in_priority_class;
        rel_mem[cnt_r[IW-1:0]] <= (in_satisfied_count != '0) && (in_unsatisfied_count != '0)
                                  && (in_reliability_threshold >= in_face_reliability);
        cnt_r <= cnt_r + CW'(1);
        n_r <= '0;
        scan_r <= '0;
        cls_r <= '0;
        sdone_r <= 1'b0;
      end
      if (cmd.sort_step && !sdone_r) begin
        if (scan_r < cnt_r && rel_mem[scan_r[IW-1:0]] && c_mem[scan_r[IW-1:0]] == cls_r) begin
          ord_mem[n_r[IW-1:0]] <= scan_r[IW-1:0];
          n_r <= n_r + CW'(1);
        end
        if (scan_r + CW'(1) >= cnt_r) begin
          scan_r <= '0;
          cls_r <= cls_r + 2'd1;
          if (cls_r == 2'd3) sdone_r <= 1'b1;
        end else begin
          scan_r <= scan_r + CW'(1);
        end
      end
      if (cmd.low_init) begin
        k_r <= '0;
        a_r <= ord_mem[0];
        b_r <= ord_mem[1];
        lo_mem[ord_mem[0]] <= ONE_Q16;
      end
      if ((cmd.low_mul || cmd.up_mul) && !cmd.mul_hi) begin
        dvd_r <= {40'd0, mp};
        dvs_r <= cmd.up_mul ? p_num : p_den;
      end
      if (cmd.mul_hi) begin
        dvd_r <= dvd_r + {16'd0, mp, 24'd0};
        dstart_r <= 1'b1;
      end
      if (cmd.low_t1_take) t1_r <= dq;
      if (cmd.low_t2_mul && cmd.div_start) begin
        dvd_r <= {39'd0, t2n, 16'd0};
        dvs_r <= u_mem[b_r] * {7'd0, r_mem[b_r]};
        dstart_r <= 1'b1;
      end
      if (cmd.low_next) begin
        lo_mem[b_r] <= lo_new;
        k_r <= k_r + CW'(1);
        a_r <= b_r;
        if (k_r + CW'(2) < n_r) b_r <= ord_mem[k_r[IW-1:0] + IW'(2)];
      end
      if (cmd.up_init) begin
        up_mem[ord_mem[npos[IW-1:0]]] <= usum[32] ? SAT32 : usum[31:0];
        k_r <= npos;
        b_r <= ord_mem[npos[IW-1:0]];
        a_r <= ord_mem[npos[IW-1:0] - IW'(1)];
      end
      if (cmd.up_take) begin
        up_mem[a_r] <= dq;
        k_r <= k_r - CW'(1);
        b_r <= a_r;
        if (k_r >= CW'(2)) a_r <= ord_mem[k_r[IW-1:0] - IW'(2)];
      end
      if (cmd.emit_init) begin
        e_r <= '0;
      end
      if (cmd.emit) begin
        out_strobe <= 1'b1;
        out_content_position <= 6'(e_r);
        out_weight <= wsel;
        out_last_result <= sts.emit_last;
        e_r <= e_r + CW'(1);
      end
      if (cmd.clear) cnt_r <= '0;
    end
  end

  always_comb begin
    ubi = up_mem[ord_mem[npos[IW-1:0]]];
    usum = {1'b0, lo_mem[ord_mem[npos[IW-1:0]]]} + {1'b0, ONE_Q16};
    msum = {1'b0, lo_mem[ei]} + {1'b0, up_mem[ei]};
    wsel = ONE_Q16;
    if (!sts.few && rel_mem[ei]) begin
      if (ei == ord_mem[0]) wsel = lo_mem[ei];
      else if (ei == ord_mem[npos[IW-1:0]]) wsel = ubi;
      else wsel = msum[32:1];
    end
  end

  `ASSERT_NEXT(a_div_one, clk, rst_n, dstart_r, !ddone)
  `ASSERT_IMPL(a_emit_cnt, clk, rst_n, cmd.emit, e_r < cnt_r)
  `ASSERT_IMPL(a_load_emit, clk, rst_n, cmd.load, !cmd.emit)
endmodule
`default_nettype wire

/* src/forwarding_weight_solver.sv */
// loads: one per cycle while idle; after the last load of a face (N loaded, R relevant)
// busy stays high through the sort and, when R >= 2, a forward and a backward pass,
// with a second forward division where a threshold is below one (each division runs 96 serial steps)
// results come one per cycle, the last in the same cycle that busy drops
// throughput: one face per solve, loads wait while busy; the receiver cannot stall
// rst_n is synchronous: control and the load count clear, stores keep data
`default_nettype none
module forwarding_weight_solver
  import fws_pkg::*;
#(
  parameter int MAX_CONTENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_satisfied_count,
  input  wire logic [23:0] in_unsatisfied_count,
  input  wire logic [16:0] in_face_reliability,
  input  wire logic [16:0] in_reliability_threshold,
  input  wire logic [1:0]  in_priority_class,
  input  wire logic        in_last_content,
  output logic             out_strobe,
  output logic [5:0]       out_content_position,
  output logic [31:0]      out_weight,
  output logic             out_last_result
);
  fws_cmd_t cmd;
  fws_sts_t sts;

  fws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last_content(in_last_content),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  fws_dp #(.MAX_CONTENTS(MAX_CONTENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_satisfied_count(in_satisfied_count), .in_unsatisfied_count(in_unsatisfied_count),
    .in_face_reliability(in_face_reliability),
    .in_reliability_threshold(in_reliability_threshold),
    .in_priority_class(in_priority_class), .sts(sts), .out_strobe(out_strobe),
    .out_content_position(out_content_position), .out_weight(out_weight),
    .out_last_result(out_last_result)
  );
endmodule
`default_nettype wire
